### src/clnws_pkg.sv
// Shared types, command codes and strobe decode for the LCD nibble sequencer.
package clnws_pkg;

   // request opcodes
   localparam logic [1:0] OP_INIT  = 2'd0;
   localparam logic [1:0] OP_BEGIN = 2'd1;
   localparam logic [1:0] OP_CHAR  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   // queued job kinds
   localparam logic [2:0] JOB_INIT  = 3'd0;
   localparam logic [2:0] JOB_BEGIN = 3'd1;
   localparam logic [2:0] JOB_DATA  = 3'd2;
   localparam logic [2:0] JOB_LINE2 = 3'd3;
   localparam logic [2:0] JOB_CLEAR = 3'd4;

   // LCD command bytes
   localparam logic [7:0] CMD_CLEAR     = 8'h01;
   localparam logic [7:0] CMD_HOME      = 8'h03;
   localparam logic [7:0] CMD_ENTRY     = 8'h04 | 8'h02;
   localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
   localparam logic [7:0] CMD_DISP_ON   = 8'h08 | 8'h04;
   localparam logic [7:0] CMD_FUNC_8BIT = 8'h20 | 8'h10 | 8'h08;
   localparam logic [7:0] CMD_FUNC_4BIT = 8'h20 | 8'h08;
   localparam logic [7:0] CMD_CGRAM0    = 8'h40 | 8'h00;
   localparam logic [7:0] CMD_DDRAM0    = 8'h80 | 8'h00;
   localparam logic [7:0] CMD_DDRAM_L2  = 8'h80 | 8'h40;

   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_LF  = 8'h0a;
   localparam logic [7:0] CHAR_CR  = 8'h0d;

   localparam logic [5:0] PAUSE_POWER_UP = 6'd40;
   localparam logic [5:0] PAUSE_FUNC_SET = 6'd5;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] code;
   } job_type;

   typedef struct packed {
      logic       reg_select;
      logic [3:0] nibble;
      logic [5:0] pause_before_ms;
      logic [1:0] pause_after_ms;
   } strobe_type;

   // number of strobes a job produces
   function automatic logic [3:0] job_length(input logic [2:0] kind);
      logic [3:0] len;
      unique case (kind)
         JOB_INIT:  len = 4'd14;
         JOB_BEGIN: len = 4'd6;
         default:   len = 4'd2;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] job_byte(input logic [2:0] kind, input logic [2:0] idx,
                                           input logic [7:0] code);
      logic [7:0] b;
      b = CMD_CLEAR;
      unique case (kind)
         JOB_INIT: begin
            unique case (idx)
               3'd0:    b = CMD_FUNC_8BIT;
               3'd1:    b = CMD_FUNC_4BIT;
               3'd2:    b = CMD_DISP_OFF;
               3'd3:    b = CMD_CLEAR;
               3'd4:    b = CMD_HOME;
               3'd5:    b = CMD_ENTRY;
               default: b = CMD_DISP_ON;
            endcase
         end
         JOB_BEGIN: begin
            unique case (idx)
               3'd0:    b = CMD_HOME;
               3'd1:    b = CMD_CGRAM0;
               default: b = CMD_DDRAM0;
            endcase
         end
         JOB_DATA:  b = code;
         JOB_LINE2: b = CMD_DDRAM_L2;
         default:   b = CMD_CLEAR;
      endcase
      return b;
   endfunction

   // strobe for one step of a job; odd steps carry the low nibble
   function automatic strobe_type job_strobe(input job_type job, input logic [3:0] step);
      strobe_type s;
      logic [7:0] b;
      b = job_byte(job.kind, step[3:1], job.code);
      s.reg_select = (job.kind == JOB_DATA);
      s.nibble = step[0] ? b[3:0] : b[7:4];
      s.pause_before_ms = '0;
      if (job.kind == JOB_INIT && step == 4'd0) s.pause_before_ms = PAUSE_POWER_UP;
      if (job.kind == JOB_INIT && step == 4'd2) s.pause_before_ms = PAUSE_FUNC_SET;
      if (!step[0])
         s.pause_after_ms = 2'd0;
      else if (!s.reg_select && (b == CMD_CLEAR || b == CMD_HOME))
         s.pause_after_ms = 2'd2;
      else
         s.pause_after_ms = 2'd1;
      return s;
   endfunction

endpackage

### src/clnws_front.sv
// Front end: accepts requests, tracks the initialized flag, turns requests into jobs.
module clnws_front
   import clnws_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_accept,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_char_code,
   output logic       push,
   output job_type    push_job
);

   logic init_ff, init_in;
   logic has_job;

   always_comb begin
      init_in       = init_ff;
      has_job       = 1'b0;
      push_job.kind = JOB_CLEAR;
      push_job.code = req_char_code;
      unique case (req_opcode)
         OP_INIT: begin
            push_job.kind = JOB_INIT;
            has_job       = !init_ff;
            if (req_accept) init_in = 1'b1;
         end
         OP_BEGIN: begin
            push_job.kind = JOB_BEGIN;
            has_job       = init_ff;
         end
         OP_CHAR: begin
            if (req_char_code == CHAR_LF || req_char_code == CHAR_CR) begin
               push_job.kind = JOB_LINE2;
               has_job       = init_ff;
            end else begin
               push_job.kind = JOB_DATA;
               has_job       = init_ff && (req_char_code != CHAR_NUL);
            end
         end
         default: begin
            push_job.kind = JOB_CLEAR;
            has_job       = init_ff;
         end
      endcase
   end

   assign push = req_accept && has_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= 1'b0;
      end else begin
         init_ff <= init_in;
      end
   end

endmodule

### src/clnws_queue.sv
// Small job queue between the front end and the strobe sequencer.
module clnws_queue
   import clnws_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type             slots_ff [DEPTH];
   logic    [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic    [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic    [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ptr_ff] <= push_job;
   end

endmodule

### src/clnws_back.sv
// Back end: steps through a job's strobes into the output register.
module clnws_back
   import clnws_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  job_type    head_job,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output strobe_type rsp_strobe,
   output logic       rsp_last
);

   logic [3:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   strobe_type strobe_ff;
   logic       last_ff;
   logic       load;
   logic       final_step;

   assign load       = head_valid && (!valid_ff || rsp_ready);
   assign final_step = (step_ff == job_length(head_job.kind) - 4'd1);
   assign pop        = load && final_step;

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         step_in  = final_step ? 4'd0 : step_ff + 4'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         strobe_ff <= job_strobe(head_job, step_ff);
         last_ff   <= final_step;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_last   = last_ff;

endmodule

### src/char_lcd_nibble_write_sequencer_core.sv
// Top level of the character LCD 4-bit write sequencer.
//
// Requests arrive on req_*: opcode in req_tuser, character byte in req_tdata.
// Each request becomes zero or more nibble strobes on rsp_*, high nibble
// first, with register select in rsp_tuser and rsp_tlast on the final strobe
// of the request. Initialize gives 14 strobes, begin-text 6, a character,
// newline or clear 2; a zero byte, a repeated initialize, or anything but
// initialize before the first initialize gives none.
// The front end classifies a request in the cycle it is accepted and queues
// a job; the back end emits one strobe per cycle while rsp_tready does not
// stall it, from the queue head into an output register. A request's first
// strobe passes through a queue slot and then the output register; the
// throughput is set by the single strobe register. req_tready drops only
// when the job queue (QUEUE_DEPTH entries) is full. A stalled rsp_tready holds
// the output register and, once the queue fills, the request side.
// Reset clears the initialized flag, the queue and the output valid.
module char_lcd_nibble_write_sequencer_core
   import clnws_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [3:0] nibble, [9:4] pause_before_ms,
                                    // [11:10] pause_after_ms, [15:12] zero
   output logic        rsp_tuser,   // [0] reg_select
   output logic        rsp_tlast
);

   logic       req_accept;
   logic       push, full, pop, head_valid;
   job_type    push_job, head_job;
   strobe_type rsp_strobe;

   assign req_tready = !full;
   assign req_accept = req_tvalid && req_tready;

   clnws_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_accept    (req_accept),
      .req_opcode    (req_tuser),
      .req_char_code (req_tdata),
      .push          (push),
      .push_job      (push_job)
   );

   clnws_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   clnws_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_strobe (rsp_strobe),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tuser = rsp_strobe.reg_select;
   assign rsp_tdata = {4'd0, rsp_strobe.pause_after_ms, rsp_strobe.pause_before_ms,
                       rsp_strobe.nibble};

endmodule

### src/clnws_checker.sv
// Port-level checks for the LCD nibble sequencer, bound to the top level.
module clnws_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled strobe holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled strobe changed");

   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("strobe valid right after reset");

   // a high nibble never ends a request
   a_high_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11:10] == 2'd0 |-> !rsp_tlast)
      else $error("high nibble marked last");

   // long pauses belong to command strobes only
   a_pause_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[9:4] != 6'd0 || rsp_tdata[11:10] == 2'd2) |-> !rsp_tuser)
      else $error("data strobe with command pause");

endmodule

bind char_lcd_nibble_write_sequencer_core clnws_checker u_clnws_checker (.*);
